>>> design/upd_pkg.sv
// ----------------------------------------------------------------------------
// upd_pkg
// Shared types and constants for the percent-escape decoder.
// ----------------------------------------------------------------------------
package upd_pkg;

    localparam int unsigned MapWidth   = 64;
    localparam int unsigned MapCount   = 4;
    localparam int unsigned CfgIdxBits = 2;

    // Escape phase codes; the unused fourth code behaves as plain text
    localparam logic [1:0] PH_TEXT   = 2'd0;
    localparam logic [1:0] PH_DIGIT1 = 2'd1;
    localparam logic [1:0] PH_DIGIT2 = 2'd2;

    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_0       = 8'h30;
    localparam logic [7:0] CH_9       = 8'h39;
    localparam logic [7:0] CH_UA      = 8'h41;
    localparam logic [7:0] CH_UF      = 8'h46;
    localparam logic [7:0] CH_LA      = 8'h61;
    localparam logic [7:0] CH_LF      = 8'h66;
    localparam logic [7:0] CH_NUL     = 8'h00;

    typedef struct packed {
        logic [1:0] phase;
        logic [3:0] high_nibble;
        logic       discarding;
    } state_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        logic       err;
        logic       last;
    } result_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] nibble;
    } hex_t;

    function automatic hex_t hex_value(input logic [7:0] ch);
        hex_t h;
        logic [7:0] d;
        h = '{ok: 1'b0, nibble: 4'd0};
        d = 8'd0;
        if (ch >= CH_0 && ch <= CH_9)
        begin
            d = ch - CH_0;
            h = '{ok: 1'b1, nibble: d[3:0]};
        end
        else if (ch >= CH_UA && ch <= CH_UF)
        begin
            d = ch - CH_UA + 8'd10;
            h = '{ok: 1'b1, nibble: d[3:0]};
        end
        else if (ch >= CH_LA && ch <= CH_LF)
        begin
            d = ch - CH_LA + 8'd10;
            h = '{ok: 1'b1, nibble: d[3:0]};
        end
        return h;
    endfunction

endpackage

>>> design/upd_step.sv
// ----------------------------------------------------------------------------
// upd_step
// Next-state and result logic for one byte of the escaped string.
// ----------------------------------------------------------------------------
module upd_step (
    input  upd_pkg::state_t  st,
    input  logic [7:0]       data,
    input  logic             last,
    input  logic [255:0]     illegal_map,
    output upd_pkg::state_t  st_next,
    output upd_pkg::result_t res
);
    import upd_pkg::*;

    hex_t       hx;
    logic [7:0] decoded;
    logic       bad_decoded;

    assign hx          = hex_value(data);
    assign decoded     = {st.high_nibble, hx.nibble};
    assign bad_decoded = (decoded == CH_NUL) || illegal_map[decoded];

    always_comb
    begin
        st_next = st;
        res     = '{valid: 1'b0, data: 8'd0, err: 1'b0, last: 1'b0};
        if (st.discarding)
        begin
            if (last)
            begin
                st_next = '{phase: PH_TEXT, high_nibble: 4'd0, discarding: 1'b0};
            end
        end
        else
        begin
            case (st.phase)
                PH_DIGIT1:
                begin
                    if (!hx.ok || last)
                    begin
                        st_next = '{phase: PH_TEXT, high_nibble: 4'd0, discarding: !last};
                        res     = '{valid: 1'b1, data: 8'd0, err: 1'b1, last: 1'b1};
                    end
                    else
                    begin
                        st_next.high_nibble = hx.nibble;
                        st_next.phase       = PH_DIGIT2;
                    end
                end
                PH_DIGIT2:
                begin
                    if (!hx.ok || bad_decoded)
                    begin
                        st_next = '{phase: PH_TEXT, high_nibble: 4'd0, discarding: !last};
                        res     = '{valid: 1'b1, data: 8'd0, err: 1'b1, last: 1'b1};
                    end
                    else
                    begin
                        st_next = '{phase: PH_TEXT, high_nibble: 4'd0, discarding: 1'b0};
                        res     = '{valid: 1'b1, data: decoded, err: 1'b0, last: last};
                    end
                end
                default:
                begin
                    st_next.phase = PH_TEXT;
                    if (data == CH_PERCENT)
                    begin
                        if (last)
                        begin
                            st_next = '{phase: PH_TEXT, high_nibble: 4'd0, discarding: 1'b0};
                            res     = '{valid: 1'b1, data: 8'd0, err: 1'b1, last: 1'b1};
                        end
                        else
                        begin
                            st_next.phase = PH_DIGIT1;
                        end
                    end
                    else
                    begin
                        res = '{valid: 1'b1, data: data, err: 1'b0, last: last};
                    end
                end
            endcase
        end
    end

endmodule

>>> design/url_percent_unescape_decoder_unit.sv
// ----------------------------------------------------------------------------
// url_percent_unescape_decoder_unit
// Percent-escape decoder: one byte in per word, at most one decoded byte or
// an error word out.
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  in        sink       in_valid / in_stall   in_byte, in_last
//  out       source     out_valid / out_stall out_byte, is_error, out_last
//  cfg       sink       cfg_we               cfg_index, cfg_data
//
// One word per cycle while out_stall does not block; out_valid rises once an
// accepted word is decoded from the input register into the result register.
// Reset clears the escape state, the illegal map and both valid flags.
// out_stall holds the result register; the input register keeps accepting
// while the held word produces no result or the result register drains.
module url_percent_unescape_decoder_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [7:0]                        in_byte,
    input  logic                              in_last,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [7:0]                        out_byte,
    output logic                              is_error,
    output logic                              out_last,
    input  logic                              cfg_we,
    input  logic [upd_pkg::CfgIdxBits-1:0]    cfg_index,
    input  logic [upd_pkg::MapWidth-1:0]      cfg_data
);
    import upd_pkg::*;

    logic [MapWidth-1:0] map_reg [MapCount];

    logic       s1_valid_reg;
    logic [7:0] s1_byte_reg;
    logic       s1_last_reg;

    state_t     st_reg, st_next;
    result_t    res;

    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic       out_err_reg;
    logic       out_last_reg;

    logic       out_free;
    logic       s1_adv;
    logic       in_take;

    upd_step u_step (
        .st          (st_reg),
        .data        (s1_byte_reg),
        .last        (s1_last_reg),
        .illegal_map ({map_reg[3], map_reg[2], map_reg[1], map_reg[0]}),
        .st_next     (st_next),
        .res         (res)
    );

    assign out_free = !out_valid_reg || !out_stall;
    assign s1_adv   = s1_valid_reg && (!res.valid || out_free);
    assign in_stall = s1_valid_reg && !s1_adv;
    assign in_take  = in_valid && !in_stall;

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign is_error  = out_err_reg;
    assign out_last  = out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MapCount; i++)
            begin
                map_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            map_reg[cfg_index] <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            st_reg        <= '{phase: PH_TEXT, high_nibble: 4'd0, discarding: 1'b0};
        end
        else
        begin
            if (in_take)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_adv)
            begin
                st_reg <= st_next;
            end

            if (s1_adv && res.valid)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_byte_reg <= in_byte;
            s1_last_reg <= in_last;
        end
        if (s1_adv && res.valid)
        begin
            out_byte_reg <= res.data;
            out_err_reg  <= res.err;
            out_last_reg <= res.last;
        end
    end

    // error word always closes the string and carries a zero byte
    a_err_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_error |-> out_last && out_byte == 8'd0)
        else $error("error word malformed");

    a_discard_text: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg.discarding |-> st_reg.phase == PH_TEXT)
        else $error("discarding while inside an escape");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg && res.valid && out_valid_reg && out_stall)
        else $error("input stalled without a blocked result");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(out_byte) && $stable(is_error))
        else $error("held result overwritten");

endmodule

>>> bench/tb_url_percent_unescape_decoder_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_url_percent_unescape_decoder_unit
// Self-checking bench for the percent-escape decoder. A directed table runs
// first: pass-through extremes, both hex cases, truncated escapes, bad digits,
// a zero decode and illegal-map hits. Random strings follow, mostly well
// formed, under several illegal maps and idling patterns. Every output word is
// compared with a behavioural decoder kept in step with the accepted input.
// ----------------------------------------------------------------------------
module tb_url_percent_unescape_decoder_unit;

    import upd_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int DRAIN_CYCLES  = 4;
    localparam int PHASES        = 8;
    localparam int PHASE_WORDS   = 150;
    localparam int HOLD_CYCLES   = 80;
    localparam int DIR_ROWS      = 27;
    localparam int MARKED_FROM   = 20;

    typedef enum logic [1:0] {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;
    typedef enum logic [1:0] {ROW_PREDICT, ROW_NONE, ROW_RESULT} row_kind_t;

    typedef struct packed {
        logic [7:0] data;
        logic       err;
        logic       last;
    } decoded_t;

    typedef struct packed {
        logic [7:0] b;
        logic       l;
        row_kind_t  kind;
        decoded_t   want;
    } dir_row_t;

    localparam decoded_t NO_WORD  = '0;
    localparam decoded_t ERR_WORD = '{data: CH_NUL, err: 1'b1, last: 1'b1};

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic [7:0]            in_byte;
    logic                  in_last;
    logic                  out_valid;
    logic                  out_stall;
    logic [7:0]            out_byte;
    logic                  is_error;
    logic                  out_last;
    logic                  cfg_we;
    logic [CfgIdxBits-1:0] cfg_index;
    logic [MapWidth-1:0]   cfg_data;

    // decoder model state
    logic [1:0]            esc_phase;
    logic [3:0]            esc_high;
    logic                  dropping;
    logic [MapWidth-1:0]   illegal_map [MapCount];
    logic [MapWidth-1:0]   map_plan [MapCount];

    decoded_t              decoded_q [$];
    decoded_t              head_word;
    idle_mode_t            idle_mode;
    bit                    hold_req;
    int                    hold_left;
    int                    error_count;
    int                    sent_items;
    int                    cycle_count;

    dir_row_t dir_rows [DIR_ROWS] = '{
        '{8'h01, 1'b0, ROW_RESULT,  '{8'h01, 1'b0, 1'b0}},
        '{8'hFF, 1'b0, ROW_RESULT,  '{8'hFF, 1'b0, 1'b0}},
        '{8'h00, 1'b1, ROW_RESULT,  '{8'h00, 1'b0, 1'b1}},
        '{8'h25, 1'b0, ROW_NONE,    NO_WORD},
        '{8'h36, 1'b0, ROW_NONE,    NO_WORD},
        '{8'h66, 1'b1, ROW_PREDICT, NO_WORD},
        // decodes to zero, then the tail is dropped
        '{8'h25, 1'b0, ROW_NONE,    NO_WORD},
        '{8'h30, 1'b0, ROW_NONE,    NO_WORD},
        '{8'h30, 1'b0, ROW_RESULT,  ERR_WORD},
        '{8'h71, 1'b0, ROW_NONE,    NO_WORD},
        '{8'h71, 1'b1, ROW_NONE,    NO_WORD},
        // string ends on the escape, then on the first digit
        '{8'h25, 1'b1, ROW_RESULT,  ERR_WORD},
        '{8'h25, 1'b0, ROW_NONE,    NO_WORD},
        '{8'h61, 1'b1, ROW_RESULT,  ERR_WORD},
        // zero byte as first digit
        '{8'h25, 1'b0, ROW_NONE,    NO_WORD},
        '{8'h00, 1'b0, ROW_RESULT,  ERR_WORD},
        '{8'h47, 1'b1, ROW_NONE,    NO_WORD},
        // bad second digit
        '{8'h25, 1'b0, ROW_NONE,    NO_WORD},
        '{8'h39, 1'b0, ROW_NONE,    NO_WORD},
        '{8'h47, 1'b1, ROW_RESULT,  ERR_WORD},
        // from here 'A', '?', 0xFF and 0x00 are marked illegal; plain bytes ignore the map
        '{8'h41, 1'b0, ROW_RESULT,  '{8'h41, 1'b0, 1'b0}},
        '{8'h25, 1'b0, ROW_NONE,    NO_WORD},
        '{8'h34, 1'b0, ROW_NONE,    NO_WORD},
        '{8'h31, 1'b1, ROW_RESULT,  ERR_WORD},
        '{8'h25, 1'b0, ROW_NONE,    NO_WORD},
        '{8'h46, 1'b0, ROW_NONE,    NO_WORD},
        '{8'h45, 1'b1, ROW_PREDICT, NO_WORD}
    };

    url_percent_unescape_decoder_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_byte   (in_byte),
        .in_last   (in_last),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .is_error  (is_error),
        .out_last  (out_last),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    function automatic int nibble_of(input logic [7:0] c);
        if (c >= CH_0 && c <= CH_9)
        begin
            return int'(c) - int'(CH_0);
        end
        if (c >= CH_UA && c <= CH_UF)
        begin
            return int'(c) - int'(CH_UA) + 10;
        end
        if (c >= CH_LA && c <= CH_LF)
        begin
            return int'(c) - int'(CH_LA) + 10;
        end
        return -1;
    endfunction

    function automatic bit reject_string(input logic l, output decoded_t r);
        esc_phase = PH_TEXT;
        esc_high  = 4'h0;
        dropping  = ~l;
        r = ERR_WORD;
        return 1'b1;
    endfunction

    // one input word in; returns 1 when it yields an output word
    function automatic bit decode_word(input logic [7:0] b, input logic l,
                                       output decoded_t r);
        int         d;
        logic [7:0] v;
        r = NO_WORD;
        d = nibble_of(b);
        if (dropping)
        begin
            if (l)
            begin
                dropping  = 1'b0;
                esc_phase = PH_TEXT;
                esc_high  = 4'h0;
            end
            return 1'b0;
        end
        if (esc_phase == PH_DIGIT1)
        begin
            if (d < 0 || l)
            begin
                return reject_string(l, r);
            end
            esc_high  = d[3:0];
            esc_phase = PH_DIGIT2;
            return 1'b0;
        end
        if (esc_phase == PH_DIGIT2)
        begin
            if (d < 0)
            begin
                return reject_string(l, r);
            end
            v = {esc_high, d[3:0]};
            if (v == CH_NUL || illegal_map[v[7:6]][v[5:0]])
            begin
                return reject_string(l, r);
            end
            esc_phase = PH_TEXT;
            esc_high  = 4'h0;
            r = '{data: v, err: 1'b0, last: l};
            return 1'b1;
        end
        esc_phase = PH_TEXT;
        if (b == CH_PERCENT)
        begin
            if (l)
            begin
                return reject_string(l, r);
            end
            esc_phase = PH_DIGIT1;
            return 1'b0;
        end
        r = '{data: b, err: 1'b0, last: l};
        return 1'b1;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10)
        begin
            return CH_0 + 8'(n);
        end
        return ($urandom_range(1) ? CH_UA : CH_LA) + 8'(n) - 8'd10;
    endfunction

    function automatic logic [MapWidth-1:0] sparse_map();
        return {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
    endfunction

    task automatic send_word(input logic [7:0] b, input logic l,
                             input row_kind_t kind, input decoded_t want);
        int       gap;
        bit       has;
        decoded_t got;
        gap = 0;
        if (idle_mode == IDLE_SENDER)
        begin
            while (gap < 40 && $urandom_range(99) < 68) gap++;
        end
        else if (idle_mode == IDLE_BOTH)
        begin
            while (gap < 40 && $urandom_range(99) < 10) gap++;
        end
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        in_last  <= l;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        has = decode_word(b, l, got);
        if (kind == ROW_RESULT)
        begin
            decoded_q.push_back(want);
        end
        else if (kind == ROW_PREDICT && has)
        begin
            decoded_q.push_back(got);
        end
        sent_items++;
    endtask

    // sender stops until every expected word is out and the pipe is empty
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (decoded_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_map_plan();
        for (int i = 0; i < MapCount; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= CfgIdxBits'(i);
            cfg_data  <= map_plan[i];
            @(posedge clk);
            illegal_map[i] = map_plan[i];
        end
        cfg_we <= 1'b0;
    endtask

    task automatic send_random_string();
        logic [7:0] seq [$];
        logic [7:0] c;
        logic [7:0] v;
        int         len;
        int         pick;
        len = $urandom_range(1, 8);
        for (int k = 0; k < len; k++)
        begin
            if ($urandom_range(99) < 55)
            begin
                c = 8'($urandom_range(255));
                if (c == CH_PERCENT)
                begin
                    c = 8'h2B;
                end
                seq.push_back(c);
            end
            else
            begin
                v = ($urandom_range(15) == 0) ? CH_NUL : 8'($urandom_range(255));
                seq.push_back(CH_PERCENT);
                seq.push_back(hex_char(v[7:4]));
                seq.push_back(hex_char(v[3:0]));
            end
        end
        // broken tail: bare escape, one digit, or a noise digit
        if ($urandom_range(99) < 20)
        begin
            pick = $urandom_range(3);
            seq.push_back(CH_PERCENT);
            if (pick == 1 || pick == 3)
            begin
                seq.push_back(hex_char(4'($urandom_range(15))));
            end
            if (pick >= 2)
            begin
                seq.push_back(8'($urandom_range(255)));
            end
            if ($urandom_range(1))
            begin
                seq.push_back(8'($urandom_range(255)));
            end
        end
        foreach (seq[i])
        begin
            send_word(seq[i], i == seq.size() - 1, ROW_PREDICT, NO_WORD);
        end
    endtask

    // receiver: random stalls per mode, plus a long hold-off on request
    initial
    begin
        out_stall <= 1'b0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (idle_mode == IDLE_RECEIVER)
            begin
                out_stall <= ($urandom_range(99) < 68);
            end
            else if (idle_mode == IDLE_BOTH)
            begin
                out_stall <= ($urandom_range(99) < 10);
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (decoded_q.size() == 0)
            begin
                $error("unexpected word: out_byte %h is_error %b out_last %b",
                       out_byte, is_error, out_last);
                error_count++;
            end
            else
            begin
                head_word = decoded_q.pop_front();
                if (out_byte !== head_word.data)
                begin
                    $error("out_byte: expected %h, got %h", head_word.data, out_byte);
                    error_count++;
                end
                if (is_error !== head_word.err)
                begin
                    $error("is_error: expected %b, got %b", head_word.err, is_error);
                    error_count++;
                end
                if (out_last !== head_word.last)
                begin
                    $error("out_last: expected %b, got %b", head_word.last, out_last);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_byte   <= 8'h00;
        in_last   <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        idle_mode   = IDLE_NONE;
        hold_req    = 1'b0;
        error_count = 0;
        sent_items  = 0;
        cycle_count = 0;
        esc_phase   = PH_TEXT;
        esc_high    = 4'h0;
        dropping    = 1'b0;
        foreach (illegal_map[i]) illegal_map[i] = '0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < DIR_ROWS; r++)
        begin
            if (r == MARKED_FROM)
            begin
                wait_drained();
                map_plan[0] = 64'h8000_0000_0000_0001;
                map_plan[1] = 64'h0000_0000_0000_0002;
                map_plan[2] = '0;
                map_plan[3] = 64'h8000_0000_0000_0000;
                write_map_plan();
            end
            send_word(dir_rows[r].b, dir_rows[r].l, dir_rows[r].kind, dir_rows[r].want);
        end

        for (int p = 0; p < PHASES; p++)
        begin
            wait_drained();
            foreach (map_plan[i])
            begin
                if (p == 0)
                begin
                    map_plan[i] = '0;
                end
                else if (p == 1)
                begin
                    map_plan[i] = '1;
                end
                else
                begin
                    map_plan[i] = sparse_map();
                end
            end
            write_map_plan();
            idle_mode = idle_mode_t'(p % 4);
            // first phase: long output hold-off so the input side backs up
            if (p == 0)
            begin
                hold_req = 1'b1;
            end
            sent_items = 0;
            while (sent_items < PHASE_WORDS) send_random_string();
        end

        wait_drained();
        repeat (10) @(posedge clk);
        if (error_count == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
